### rtl/lru_page_frame_manager_core_macros.svh
// ============================================================================
// LRU page frame manager assertion macros
// Shared property forms used by the checker of the page frame manager.
// ============================================================================
`ifndef LRU_PAGE_FRAME_MANAGER_CORE_MACROS_SVH
`define LRU_PAGE_FRAME_MANAGER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LPFM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("page frame manager: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LPFM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("page frame manager: next-cycle check failed");

`endif

### rtl/lpfm_pkg.sv
// ============================================================================
// LRU page frame manager package
// Transaction types, operation and status codes and register indexes.
// ============================================================================
package lpfm_pkg;

   localparam int PAGE_ID_BITS   = 16;
   localparam int DATA_BITS      = 32;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 5;

   localparam logic [1:0] FUNC_LOAD  = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_WRITE = 2'd2;
   localparam logic [1:0] FUNC_FREE  = 2'd3;

   localparam logic [1:0] STATUS_HIT       = 2'd0;
   localparam logic [1:0] STATUS_FAULT     = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STATUS_LOADED    = 2'd3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAMES_IN_USE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SWAP_LIMIT    = 2'd1;

   localparam logic [1:0] AGE_NONE  = 2'd0;
   localparam logic [1:0] AGE_TOUCH = 2'd1;
   localparam logic [1:0] AGE_DROP  = 2'd2;
   localparam logic [1:0] AGE_FILL  = 2'd3;

   typedef struct packed {
      logic [1:0]              func;
      logic [PAGE_ID_BITS-1:0] page_id;
      logic [DATA_BITS-1:0]    data_in;
   } req_type;

   typedef struct packed {
      logic [DATA_BITS-1:0]    read_data;
      logic [1:0]              status;
      logic                    evicted_valid;
      logic [PAGE_ID_BITS-1:0] evicted_page;
      logic                    evicted_to_swap;
      logic                    swap_overflow;
   } rsp_type;

   typedef struct packed {
      logic [1:0] op;
      logic       evict;
   } age_ctl_type;

endpackage

### rtl/lpfm_ram.sv
// ============================================================================
// LRU page frame manager RAM
// Single write port, single read port, registered read data.
// ============================================================================
module lpfm_ram #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 48,
   parameter int AW    = 3
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/lpfm_age_unit.sv
// ============================================================================
// LRU page frame manager age unit
// Computes the next frame valid bits and recency ages for one operation.
// ============================================================================
module lpfm_age_unit #(
   parameter int NUM_FRAMES = 8,
   parameter int FR_IDX     = 3
) (
   input  lpfm_pkg::age_ctl_type               ctl,
   input  logic [FR_IDX-1:0]                   idx,
   input  logic [FR_IDX-1:0]                   age,
   input  logic [FR_IDX-1:0]                   vic_age,
   input  logic [NUM_FRAMES-1:0]               valid_cur,
   input  logic [NUM_FRAMES-1:0][FR_IDX-1:0]   rec_cur,
   output logic [NUM_FRAMES-1:0]               valid_nxt,
   output logic [NUM_FRAMES-1:0][FR_IDX-1:0]   rec_nxt
);
   import lpfm_pkg::*;

   always_comb begin
      valid_nxt = valid_cur;
      rec_nxt   = rec_cur;
      for (int j = 0; j < NUM_FRAMES; j++) begin
         case (ctl.op)
            AGE_TOUCH: begin
               if (FR_IDX'(j) == idx) begin
                  rec_nxt[j] = '0;
               end else if (valid_cur[j] && rec_cur[j] < age) begin
                  rec_nxt[j] = rec_cur[j] + 1'b1;
               end
            end
            AGE_DROP: begin
               if (FR_IDX'(j) == idx) begin
                  valid_nxt[j] = 1'b0;
                  rec_nxt[j]   = '0;
               end else if (valid_cur[j] && rec_cur[j] > age) begin
                  rec_nxt[j] = rec_cur[j] - 1'b1;
               end
            end
            AGE_FILL: begin
               // An evicted victim leaves first, then every other page ages by one.
               if (FR_IDX'(j) == idx) begin
                  valid_nxt[j] = 1'b1;
                  rec_nxt[j]   = '0;
               end else if (valid_cur[j]) begin
                  if (ctl.evict && rec_cur[j] > vic_age) begin
                     rec_nxt[j] = rec_cur[j];
                  end else begin
                     rec_nxt[j] = rec_cur[j] + 1'b1;
                  end
               end
            end
            default: begin
               rec_nxt[j] = rec_cur[j];
            end
         endcase
      end
   end

endmodule

### rtl/lru_page_frame_manager_core.sv
// ============================================================================
// LRU page frame manager core
// Page frames under LRU replacement with a swap store for dirty victims.
// ============================================================================
// One transaction at a time. After acceptance the sequencer reads every frame
// entry through the frame RAM port, then every swap slot through the swap
// RAM port, applies all updates together and presents the result, which
// holds while rsp_stall is high. A write to frames_in_use sweeps every
// frame, during which no transaction or register write is taken.
module lru_page_frame_manager_core #(
   parameter int NUM_FRAMES = 8,
   parameter int SWAP_SLOTS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  lpfm_pkg::req_type                       req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output lpfm_pkg::rsp_type                       rsp_data,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [lpfm_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [lpfm_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);
   import lpfm_pkg::*;

   localparam int FR_IDX = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int SW_IDX = (SWAP_SLOTS > 1) ? $clog2(SWAP_SLOTS) : 1;
   localparam int SC_W   = ((FR_IDX > SW_IDX) ? FR_IDX : SW_IDX) + 1;
   localparam int CW     = SC_W + 6;
   localparam int WW     = PAGE_ID_BITS + DATA_BITS;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_FSCAN  = 3'd1;
   localparam logic [2:0] ST_SSCAN  = 3'd2;
   localparam logic [2:0] ST_UPDATE = 3'd3;
   localparam logic [2:0] ST_RESP   = 3'd4;
   localparam logic [2:0] ST_CDROP  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [SC_W-1:0] cnt_ff, cnt_in, rd_idx_ff;
   logic frd_ok_ff, srd_ok_ff;
   req_type req_ff, req_in;
   logic [3:0] frames_ff, frames_in;
   logic [4:0] slots_ff, slots_in;
   logic [NUM_FRAMES-1:0] fvalid_ff, fvalid_in, fdirty_ff, fdirty_in;
   logic [NUM_FRAMES-1:0][FR_IDX-1:0] frec_ff, frec_in;
   logic [SWAP_SLOTS-1:0] svalid_ff, svalid_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   // Scan results.
   logic f_found_ff, f_found_in;
   logic [FR_IDX-1:0] f_idx_ff, f_idx_in, f_rec_ff, f_rec_in;
   logic [DATA_BITS-1:0] f_content_ff, f_content_in;
   logic free_found_ff, free_found_in;
   logic [FR_IDX-1:0] free_idx_ff, free_idx_in;
   logic vic_any_ff, vic_any_in, vic_dirty_ff, vic_dirty_in;
   logic [FR_IDX-1:0] vic_idx_ff, vic_idx_in, vic_rec_ff, vic_rec_in;
   logic [PAGE_ID_BITS-1:0] vic_page_ff, vic_page_in;
   logic [DATA_BITS-1:0] vic_content_ff, vic_content_in;
   logic s_found_ff, s_found_in;
   logic [SW_IDX-1:0] s_idx_ff, s_idx_in;
   logic [DATA_BITS-1:0] s_content_ff, s_content_in;
   logic vs_found_ff, vs_found_in;
   logic [SW_IDX-1:0] vs_idx_ff, vs_idx_in;
   logic fs_found_ff, fs_found_in;
   logic [SW_IDX-1:0] fs_idx_ff, fs_idx_in;

   logic fram_we, sram_we;
   logic [FR_IDX-1:0] fram_waddr;
   logic [SW_IDX-1:0] sram_waddr;
   logic [WW-1:0] fram_wdata, sram_wdata, fram_rdata, sram_rdata;

   age_ctl_type age_ctl;
   logic [FR_IDX-1:0] age_idx, age_age;
   logic [NUM_FRAMES-1:0] age_valid;
   logic [NUM_FRAMES-1:0][FR_IDX-1:0] age_rec;

   logic [3:0] fr_eff;
   logic req_acc, csr_acc;
   logic [FR_IDX-1:0] sj_f;
   logic [SW_IDX-1:0] sj_s;
   logic [FR_IDX-1:0] cj;
   logic f_inr, s_inr, s_match;
   logic [PAGE_ID_BITS-1:0] f_rpage, s_rpage;
   logic is_rw, take, evict, wb_ok;
   logic [FR_IDX-1:0] k_idx;
   logic [SW_IDX-1:0] wb_slot;

   assign fr_eff    = (frames_ff == 4'd0) ? 4'd1 : frames_ff;
   assign req_stall = (state_ff != ST_IDLE) | csr_valid;
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid & ~req_stall;
   assign csr_acc   = csr_valid & csr_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   lpfm_ram #(.DEPTH(NUM_FRAMES), .WIDTH(WW), .AW(FR_IDX)) u_frame_ram (
      .clock (clock),
      .we    (fram_we),
      .waddr (fram_waddr),
      .wdata (fram_wdata),
      .raddr (cnt_ff[FR_IDX-1:0]),
      .rdata (fram_rdata)
   );

   lpfm_ram #(.DEPTH(SWAP_SLOTS), .WIDTH(WW), .AW(SW_IDX)) u_swap_ram (
      .clock (clock),
      .we    (sram_we),
      .waddr (sram_waddr),
      .wdata (sram_wdata),
      .raddr (cnt_ff[SW_IDX-1:0]),
      .rdata (sram_rdata)
   );

   lpfm_age_unit #(.NUM_FRAMES(NUM_FRAMES), .FR_IDX(FR_IDX)) u_age (
      .ctl       (age_ctl),
      .idx       (age_idx),
      .age       (age_age),
      .vic_age   (vic_rec_ff),
      .valid_cur (fvalid_ff),
      .rec_cur   (frec_ff),
      .valid_nxt (age_valid),
      .rec_nxt   (age_rec)
   );

   assign sj_f    = rd_idx_ff[FR_IDX-1:0];
   assign sj_s    = rd_idx_ff[SW_IDX-1:0];
   assign cj      = cnt_ff[FR_IDX-1:0];
   assign f_rpage = fram_rdata[WW-1:DATA_BITS];
   assign s_rpage = sram_rdata[WW-1:DATA_BITS];
   assign f_inr   = CW'(sj_f) < CW'(fr_eff);
   assign s_inr   = CW'(sj_s) < CW'(slots_ff);
   assign s_match = svalid_ff[sj_s] && (s_rpage == req_ff.page_id);

   assign is_rw   = (req_ff.func == FUNC_READ) || (req_ff.func == FUNC_WRITE);
   assign take    = !f_found_ff && ((req_ff.func == FUNC_LOAD) || (is_rw && s_found_ff));
   assign evict   = take && !free_found_ff;
   assign k_idx   = free_found_ff ? free_idx_ff : vic_idx_ff;
   assign wb_ok   = vs_found_ff || fs_found_ff;
   assign wb_slot = vs_found_ff ? vs_idx_ff : fs_idx_ff;

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      req_in         = req_ff;
      frames_in      = frames_ff;
      slots_in       = slots_ff;
      fvalid_in      = fvalid_ff;
      fdirty_in      = fdirty_ff;
      frec_in        = frec_ff;
      svalid_in      = svalid_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff;
      f_found_in     = f_found_ff;
      f_idx_in       = f_idx_ff;
      f_rec_in       = f_rec_ff;
      f_content_in   = f_content_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      vic_any_in     = vic_any_ff;
      vic_dirty_in   = vic_dirty_ff;
      vic_idx_in     = vic_idx_ff;
      vic_rec_in     = vic_rec_ff;
      vic_page_in    = vic_page_ff;
      vic_content_in = vic_content_ff;
      s_found_in     = s_found_ff;
      s_idx_in       = s_idx_ff;
      s_content_in   = s_content_ff;
      vs_found_in    = vs_found_ff;
      vs_idx_in      = vs_idx_ff;
      fs_found_in    = fs_found_ff;
      fs_idx_in      = fs_idx_ff;
      fram_we        = 1'b0;
      fram_waddr     = f_idx_ff;
      fram_wdata     = {req_ff.page_id, req_ff.data_in};
      sram_we        = 1'b0;
      sram_waddr     = wb_slot;
      sram_wdata     = {vic_page_ff, vic_content_ff};
      age_ctl.op     = AGE_NONE;
      age_ctl.evict  = evict;
      age_idx        = f_idx_ff;
      age_age        = f_rec_ff;

      // Compare stage of the frame scan, one entry per cycle.
      if (frd_ok_ff && f_inr) begin
         if (!f_found_in && fvalid_ff[sj_f] && f_rpage == req_ff.page_id) begin
            f_found_in   = 1'b1;
            f_idx_in     = sj_f;
            f_rec_in     = frec_ff[sj_f];
            f_content_in = fram_rdata[DATA_BITS-1:0];
         end
         if (!free_found_in && !fvalid_ff[sj_f]) begin
            free_found_in = 1'b1;
            free_idx_in   = sj_f;
         end
         if (!vic_any_in || frec_ff[sj_f] > vic_rec_in) begin
            vic_any_in     = 1'b1;
            vic_idx_in     = sj_f;
            vic_rec_in     = frec_ff[sj_f];
            vic_page_in    = f_rpage;
            vic_content_in = fram_rdata[DATA_BITS-1:0];
            vic_dirty_in   = fdirty_ff[sj_f];
         end
      end

      // Compare stage of the swap scan. A load discards the page's own swap
      // copy first, so that slot counts as free for the victim.
      if (srd_ok_ff && s_inr) begin
         if (!s_found_in && s_match) begin
            s_found_in   = 1'b1;
            s_idx_in     = sj_s;
            s_content_in = sram_rdata[DATA_BITS-1:0];
         end
         if (!vs_found_in && svalid_ff[sj_s] && s_rpage == vic_page_ff) begin
            vs_found_in = 1'b1;
            vs_idx_in   = sj_s;
         end
         if (!fs_found_in && (!svalid_ff[sj_s] || (req_ff.func == FUNC_LOAD && s_match))) begin
            fs_found_in = 1'b1;
            fs_idx_in   = sj_s;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (csr_acc) begin
               if (csr_index == CSR_FRAMES_IN_USE) begin
                  frames_in = csr_wdata[3:0];
                  state_in  = ST_CDROP;
               end else if (csr_index == CSR_SWAP_LIMIT) begin
                  slots_in = csr_wdata;
                  for (int j = 0; j < SWAP_SLOTS; j++) begin
                     if (CW'(j) >= CW'(csr_wdata)) begin
                        svalid_in[j] = 1'b0;
                     end
                  end
               end
            end else if (req_acc) begin
               req_in        = req_data;
               f_found_in    = 1'b0;
               free_found_in = 1'b0;
               vic_any_in    = 1'b0;
               s_found_in    = 1'b0;
               vs_found_in   = 1'b0;
               fs_found_in   = 1'b0;
               state_in      = ST_FSCAN;
            end
         end
         ST_FSCAN: begin
            if (CW'(cnt_ff) == CW'(NUM_FRAMES)) begin
               cnt_in   = '0;
               state_in = ST_SSCAN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SSCAN: begin
            if (CW'(cnt_ff) == CW'(SWAP_SLOTS)) begin
               cnt_in   = '0;
               state_in = ST_UPDATE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_UPDATE: begin
            rsp_in.read_data       = '0;
            rsp_in.status          = STATUS_NOT_FOUND;
            rsp_in.evicted_valid   = evict;
            rsp_in.evicted_page    = evict ? vic_page_ff : '0;
            rsp_in.evicted_to_swap = evict && vic_dirty_ff && wb_ok;
            rsp_in.swap_overflow   = evict && vic_dirty_ff && !wb_ok;

            if (s_found_ff && ((req_ff.func == FUNC_LOAD && !f_found_ff) ||
                               req_ff.func == FUNC_FREE)) begin
               svalid_in[s_idx_ff] = 1'b0;
            end
            if (evict && vic_dirty_ff && wb_ok) begin
               sram_we             = 1'b1;
               svalid_in[wb_slot]  = 1'b1;
            end

            if (req_ff.func == FUNC_FREE) begin
               rsp_in.status = (f_found_ff || s_found_ff) ? STATUS_HIT : STATUS_NOT_FOUND;
               if (f_found_ff) begin
                  age_ctl.op           = AGE_DROP;
                  fdirty_in[f_idx_ff]  = 1'b0;
               end
            end else if (f_found_ff) begin
               age_ctl.op    = AGE_TOUCH;
               rsp_in.status = (req_ff.func == FUNC_LOAD) ? STATUS_LOADED : STATUS_HIT;
               if (req_ff.func == FUNC_READ) begin
                  rsp_in.read_data = f_content_ff;
               end else begin
                  fram_we             = 1'b1;
                  fdirty_in[f_idx_ff] = (req_ff.func == FUNC_WRITE);
               end
            end else if (take) begin
               age_ctl.op          = AGE_FILL;
               age_idx             = k_idx;
               fram_we             = 1'b1;
               fram_waddr          = k_idx;
               fdirty_in[k_idx]    = (req_ff.func == FUNC_WRITE);
               if (req_ff.func == FUNC_LOAD) begin
                  rsp_in.status = STATUS_LOADED;
               end else begin
                  rsp_in.status = STATUS_FAULT;
                  if (req_ff.func == FUNC_READ) begin
                     fram_wdata       = {req_ff.page_id, s_content_ff};
                     rsp_in.read_data = s_content_ff;
                  end
               end
            end
            fvalid_in    = age_valid;
            frec_in      = age_rec;
            rsp_valid_in = 1'b1;
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         ST_CDROP: begin
            // Frames at or beyond the new count are dropped one per cycle.
            if (fvalid_ff[cj] && CW'(cj) >= CW'(fr_eff)) begin
               age_ctl.op    = AGE_DROP;
               age_idx       = cj;
               age_age       = frec_ff[cj];
               fdirty_in[cj] = 1'b0;
            end
            fvalid_in = age_valid;
            frec_in   = age_rec;
            if (CW'(cnt_ff) == CW'(NUM_FRAMES - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         rd_idx_ff     <= '0;
         frd_ok_ff     <= 1'b0;
         srd_ok_ff     <= 1'b0;
         frames_ff     <= 4'd8;
         slots_ff      <= 5'd16;
         fvalid_ff     <= '0;
         fdirty_ff     <= '0;
         frec_ff       <= '0;
         svalid_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         f_found_ff    <= 1'b0;
         free_found_ff <= 1'b0;
         vic_any_ff    <= 1'b0;
         s_found_ff    <= 1'b0;
         vs_found_ff   <= 1'b0;
         fs_found_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rd_idx_ff     <= cnt_ff;
         frd_ok_ff     <= (state_ff == ST_FSCAN) && (CW'(cnt_ff) < CW'(NUM_FRAMES));
         srd_ok_ff     <= (state_ff == ST_SSCAN) && (CW'(cnt_ff) < CW'(SWAP_SLOTS));
         frames_ff     <= frames_in;
         slots_ff      <= slots_in;
         fvalid_ff     <= fvalid_in;
         fdirty_ff     <= fdirty_in;
         frec_ff       <= frec_in;
         svalid_ff     <= svalid_in;
         rsp_valid_ff  <= rsp_valid_in;
         f_found_ff    <= f_found_in;
         free_found_ff <= free_found_in;
         vic_any_ff    <= vic_any_in;
         s_found_ff    <= s_found_in;
         vs_found_ff   <= vs_found_in;
         fs_found_ff   <= fs_found_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      rsp_ff         <= rsp_in;
      f_idx_ff       <= f_idx_in;
      f_rec_ff       <= f_rec_in;
      f_content_ff   <= f_content_in;
      free_idx_ff    <= free_idx_in;
      vic_dirty_ff   <= vic_dirty_in;
      vic_idx_ff     <= vic_idx_in;
      vic_rec_ff     <= vic_rec_in;
      vic_page_ff    <= vic_page_in;
      vic_content_ff <= vic_content_in;
      s_idx_ff       <= s_idx_in;
      s_content_ff   <= s_content_in;
      vs_idx_ff      <= vs_idx_in;
      fs_idx_ff      <= fs_idx_in;
   end

endmodule

### rtl/lpfm_checker.sv
// ============================================================================
// LRU page frame manager checker
// Port-level checks on the transaction behavior of the core.
// ============================================================================
`include "lru_page_frame_manager_core_macros.svh"

module lpfm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input lpfm_pkg::rsp_type rsp_data
);
   import lpfm_pkg::*;

   // A stalled result holds.
   `LPFM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   // The core works on one transaction at a time.
   `LPFM_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `LPFM_ASSERT_NOW(a_no_accept_with_result, clock, reset, rsp_valid, req_stall)
   // An unknown page changes nothing and returns no data.
   `LPFM_ASSERT_NOW(a_not_found_clean, clock, reset,
      rsp_valid && rsp_data.status == STATUS_NOT_FOUND,
      !rsp_data.evicted_valid && rsp_data.read_data == '0)

endmodule

bind lru_page_frame_manager_core lpfm_checker u_lpfm_checker (.*);

### tb/sv/tb_lru_page_frame_manager_core.sv
// ============================================================================
// LRU page frame manager core testbench
// Drives load, read, write and free transactions under several frame and
// swap settings. A behavioral copy of the frame and swap state predicts
// every result, and each result is checked field by field in order.
// ============================================================================
`timescale 1ns / 1ps

module tb_lru_page_frame_manager_core;
   import lpfm_pkg::*;

   localparam int NFRM = 8;
   localparam int NSLOT = 16;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   lru_page_frame_manager_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Mirror of the frame table, swap store and registers.
   bit fr_used[NFRM];
   bit [15:0] fr_page[NFRM];
   bit [31:0] fr_data[NFRM];
   bit fr_dirty[NFRM];
   int fr_age[NFRM];
   bit sw_used[NSLOT];
   bit [15:0] sw_page[NSLOT];
   bit [31:0] sw_data[NSLOT];
   bit [3:0] frames_reg;
   bit [4:0] swap_reg;

   rsp_type pending_rsp[$];
   int errors;
   int n_sent, n_hit, n_fault, n_miss, n_evict, n_spill, n_overflow;
   bit quiet;
   int hold_len;
   bit [15:0] page_pool[12];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("lru_page_frame_manager_core test failed");
      $finish;
   end

   function automatic int frames_avail();
      int n;
      n = frames_reg;
      if (n < 1) n = 1;
      if (n > NFRM) n = NFRM;
      return n;
   endfunction

   function automatic int slots_avail();
      return (swap_reg > NSLOT) ? NSLOT : swap_reg;
   endfunction

   function automatic void frame_release(int i);
      int a;
      if (!fr_used[i]) return;
      a = fr_age[i];
      fr_used[i] = 0;
      fr_dirty[i] = 0;
      fr_age[i] = 0;
      for (int j = 0; j < NFRM; j++)
         if (fr_used[j] && fr_age[j] > a) fr_age[j]--;
   endfunction

   function automatic void frame_touch(int i);
      int a;
      a = fr_age[i];
      for (int j = 0; j < NFRM; j++)
         if (j != i && fr_used[j] && fr_age[j] < a) fr_age[j]++;
      fr_age[i] = 0;
   endfunction

   function automatic void frame_fill(int i, bit [15:0] pg, bit [31:0] d);
      for (int j = 0; j < NFRM; j++)
         if (fr_used[j]) fr_age[j]++;
      fr_used[i] = 1;
      fr_page[i] = pg;
      fr_data[i] = d;
      fr_dirty[i] = 0;
      fr_age[i] = 0;
   endfunction

   function automatic int frame_lookup(bit [15:0] pg);
      for (int j = 0; j < frames_avail(); j++)
         if (fr_used[j] && fr_page[j] == pg) return j;
      return -1;
   endfunction

   function automatic int slot_lookup(bit [15:0] pg);
      for (int j = 0; j < slots_avail(); j++)
         if (sw_used[j] && sw_page[j] == pg) return j;
      return -1;
   endfunction

   // Picks a frame for a new page, evicting the oldest one when all are taken.
   function automatic int frame_claim(ref rsp_type r);
      int v, s, oldest;
      for (int j = 0; j < frames_avail(); j++)
         if (!fr_used[j]) return j;
      v = 0;
      oldest = fr_age[0];
      for (int j = 1; j < frames_avail(); j++)
         if (fr_age[j] > oldest) begin
            oldest = fr_age[j];
            v = j;
         end
      r.evicted_valid = 1'b1;
      r.evicted_page = fr_page[v];
      if (fr_dirty[v]) begin
         s = slot_lookup(fr_page[v]);
         if (s < 0)
            for (int j = 0; j < slots_avail(); j++)
               if (!sw_used[j]) begin
                  s = j;
                  break;
               end
         if (s >= 0) begin
            sw_used[s] = 1;
            sw_page[s] = fr_page[v];
            sw_data[s] = fr_data[v];
            r.evicted_to_swap = 1'b1;
         end else begin
            r.swap_overflow = 1'b1;
         end
      end
      frame_release(v);
      return v;
   endfunction

   function automatic rsp_type page_op_result(req_type q);
      rsp_type r;
      int f, s, k;
      r = '0;
      f = frame_lookup(q.page_id);
      s = slot_lookup(q.page_id);
      case (q.func)
         FUNC_LOAD: begin
            if (f >= 0) begin
               fr_data[f] = q.data_in;
               fr_dirty[f] = 0;
               frame_touch(f);
            end else begin
               if (s >= 0) sw_used[s] = 0;
               k = frame_claim(r);
               frame_fill(k, q.page_id, q.data_in);
            end
            r.status = STATUS_LOADED;
         end
         FUNC_READ, FUNC_WRITE: begin
            if (f >= 0) begin
               frame_touch(f);
               r.status = STATUS_HIT;
            end else if (s >= 0) begin
               k = frame_claim(r);
               frame_fill(k, q.page_id, sw_data[s]);
               f = k;
               r.status = STATUS_FAULT;
            end else begin
               r.status = STATUS_NOT_FOUND;
            end
            if (f >= 0) begin
               if (q.func == FUNC_READ) begin
                  r.read_data = fr_data[f];
               end else begin
                  fr_data[f] = q.data_in;
                  fr_dirty[f] = 1;
               end
            end
         end
         default: begin
            if (f >= 0) frame_release(f);
            if (s >= 0) sw_used[s] = 0;
            r.status = (f >= 0 || s >= 0) ? STATUS_HIT : STATUS_NOT_FOUND;
         end
      endcase
      return r;
   endfunction

   function automatic int pick_gap();
      int p;
      if (quiet) return 0;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 95) return $urandom_range(1, 4);
      return $urandom_range(15, 60);
   endfunction

   // Result-side back-pressure; hold_len requests one long stall.
   int stall_left;
   always @(posedge clock) begin
      if (hold_len > 0) begin
         stall_left = hold_len;
         hold_len = 0;
      end else if (stall_left == 0 && !quiet) begin
         stall_left = pick_gap();
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic check_field(string nm, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
         $display("%0t: %s mismatch, expected %h actual %h", $realtime, nm, e, a);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %h", $realtime,
               rsp_data);
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            check_field("read_data", e.read_data, rsp_data.read_data);
            check_field("status", e.status, rsp_data.status);
            check_field("evicted_valid", e.evicted_valid, rsp_data.evicted_valid);
            check_field("evicted_page", e.evicted_page, rsp_data.evicted_page);
            check_field("evicted_to_swap", e.evicted_to_swap, rsp_data.evicted_to_swap);
            check_field("swap_overflow", e.swap_overflow, rsp_data.swap_overflow);
            case (e.status)
               STATUS_HIT: n_hit++;
               STATUS_FAULT: n_fault++;
               STATUS_NOT_FOUND: n_miss++;
               default: ;
            endcase
            n_evict += e.evicted_valid;
            n_spill += e.evicted_to_swap;
            n_overflow += e.swap_overflow;
         end
      end
   end

   task automatic send_page_op(logic [1:0] fn, logic [15:0] pg, logic [31:0] d);
      req_type q;
      int g;
      q.func = fn;
      q.page_id = pg;
      q.data_in = d;
      req_valid <= 1'b1;
      req_data <= q;
      do @(posedge clock); while (req_stall);
      pending_rsp.push_back(page_op_result(q));
      n_sent++;
      g = pick_gap();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [4:0] val);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_FRAMES_IN_USE) begin
         frames_reg = val[3:0];
         for (int j = frames_avail(); j < NFRM; j++) frame_release(j);
      end else if (idx == CSR_SWAP_LIMIT) begin
         swap_reg = val;
         for (int j = slots_avail(); j < NSLOT; j++) sw_used[j] = 0;
      end
   endtask

   task automatic test_directed();
      write_csr(CSR_FRAMES_IN_USE, 5'd2);
      write_csr(CSR_SWAP_LIMIT, 5'd1);
      send_page_op(FUNC_READ, 16'hFFFF, 32'h0);
      send_page_op(FUNC_WRITE, 16'h0000, 32'hFFFF_FFFF);
      send_page_op(FUNC_FREE, 16'h1234, 32'h0);
      send_page_op(FUNC_LOAD, 16'h0000, 32'hFFFF_FFFF);
      send_page_op(FUNC_LOAD, 16'hFFFF, 32'h0000_0000);
      send_page_op(FUNC_READ, 16'h0000, 32'h0);
      send_page_op(FUNC_LOAD, 16'h0000, 32'hA5A5_5A5A);
      send_page_op(FUNC_WRITE, 16'hFFFF, 32'h1357_9BDF);
      // A clean victim leaves without a swap copy, then hits and a miss follow.
      send_page_op(FUNC_LOAD, 16'h0001, 32'h1111_1111);
      send_page_op(FUNC_READ, 16'hFFFF, 32'h0);
      send_page_op(FUNC_WRITE, 16'h0000, 32'h2222_2222);
      send_page_op(FUNC_WRITE, 16'hFFFF, 32'h3333_3333);
      // The first dirty victim fills the only slot, so the next dirty victim is lost.
      send_page_op(FUNC_WRITE, 16'h0002, 32'h0);
      send_page_op(FUNC_LOAD, 16'h0002, 32'h4444_4444);
      send_page_op(FUNC_WRITE, 16'h0002, 32'h5555_5555);
      send_page_op(FUNC_LOAD, 16'h0003, 32'h6666_6666);
      send_page_op(FUNC_LOAD, 16'h0004, 32'h7777_7777);
      send_page_op(FUNC_LOAD, 16'hFFFF, 32'h8888_8888);
      send_page_op(FUNC_FREE, 16'hFFFF, 32'h0);
      send_page_op(FUNC_FREE, 16'h0004, 32'h0);
      send_page_op(FUNC_FREE, 16'h0004, 32'h0);
      write_csr(2'd3, 5'd7);
   endtask

   task automatic test_random(logic [3:0] frm, logic [4:0] slots, int count);
      logic [15:0] pg;
      int p;
      write_csr(CSR_FRAMES_IN_USE, {1'b0, frm});
      write_csr(CSR_SWAP_LIMIT, slots);
      for (int j = 0; j < 12; j++) page_pool[j] = 16'($urandom);
      page_pool[0] = 16'h0000;
      page_pool[1] = 16'hFFFF;
      for (int n = 0; n < count; n++) begin
         pg = ($urandom_range(0, 99) < 88) ? page_pool[$urandom_range(0, 11)]
                                            : 16'($urandom);
         p = $urandom_range(0, 99);
         if (p < 30) send_page_op(FUNC_LOAD, pg, $urandom);
         else if (p < 60) send_page_op(FUNC_READ, pg, $urandom);
         else if (p < 88) send_page_op(FUNC_WRITE, pg, $urandom);
         else send_page_op(FUNC_FREE, pg, $urandom);
      end
   endtask

   task automatic test_back_pressure();
      quiet = 1'b1;
      hold_len = 300;
      for (int n = 0; n < 20; n++)
         send_page_op(2'($urandom), page_pool[$urandom_range(0, 11)], $urandom);
      drain();
      quiet = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      frames_reg = 4'd8;
      swap_reg = 5'd16;
      quiet = 1'b0;
      hold_len = 0;
      stall_left = 0;
      errors = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(4'd8, 5'd16, 160);
      test_random(4'd1, 5'd0, 100);
      test_random(4'd3, 5'd2, 120);
      test_back_pressure();
      quiet = 1'b1;
      test_random(4'd8, 5'd0, 110);
      quiet = 1'b0;
      test_random(4'd2, 5'd16, 110);
      test_random(4'd15, 5'd31, 100);
      test_random(4'd0, 5'd5, 100);
      test_random(4'd5, 5'd1, 110);
      drain();
      $display("Sent %0d transactions over nine frame/swap settings.", n_sent);
      $display("Hits %0d, faults %0d, not found %0d, evictions %0d, to swap %0d, lost %0d.",
         n_hit, n_fault, n_miss, n_evict, n_spill, n_overflow);
      if (errors == 0)
         $display("lru_page_frame_manager_core test passed");
      else
         $display("lru_page_frame_manager_core test failed");
      $finish;
   end

endmodule

### lru_page_frame_manager_core.f
+incdir+rtl
rtl/lpfm_pkg.sv
rtl/lpfm_ram.sv
rtl/lpfm_age_unit.sv
rtl/lru_page_frame_manager_core.sv
rtl/lpfm_checker.sv
tb/sv/tb_lru_page_frame_manager_core.sv
